### hw/rtl/ltp_pkg.sv
// Shared constants, codes and control structs of the loop transport position block.
`default_nettype none

package ltp_pkg;

    // Datapath widths
    localparam int POSITION_BITS = 48;
    localparam int FRAME_BITS    = 16;
    localparam int CMD_BITS      = 3;
    localparam int CFG_IDX_BITS  = 2;
    localparam int CNT_BITS      = $clog2(POSITION_BITS);

    // Command codes
    localparam logic [CMD_BITS-1:0] CMD_BEGIN   = 3'd0;
    localparam logic [CMD_BITS-1:0] CMD_ADVANCE = 3'd1;
    localparam logic [CMD_BITS-1:0] CMD_SEEK    = 3'd2;
    localparam logic [CMD_BITS-1:0] CMD_PLAY    = 3'd3;
    localparam logic [CMD_BITS-1:0] CMD_STOP    = 3'd4;

    // Configuration register indexes
    localparam logic [CFG_IDX_BITS-1:0] CFG_LOOP_ENABLE = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_LOOP_START  = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_LOOP_END    = 2'd2;

    // Controller to datapath commands
    typedef struct packed {
        logic accept;     // take the input word, execute simple commands
        logic do_add;     // position plus frames, saturating
        logic do_check;   // loop wrap test, divider setup
        logic do_div;     // one restoring division step
        logic do_fin;     // write back the new position
        logic load_out;   // load the result register
    } ltp_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic adv_go;     // offered word is an advance that moves the position
        logic wrap;       // loop wrap needed (valid during check)
    } ltp_status_t;

endpackage

`default_nettype wire

### hw/rtl/ltp_if.sv
// Valid/ready channel interfaces: input items, results and configuration writes.
`default_nettype none

interface ltp_item_if;
    logic                                valid;
    logic                                ready;
    logic [ltp_pkg::CMD_BITS-1:0]        command;
    logic [ltp_pkg::POSITION_BITS-1:0]   seek_sample;
    logic [ltp_pkg::FRAME_BITS-1:0]      frames;

    modport source (output valid, command, seek_sample, frames, input ready);
    modport sink   (input valid, command, seek_sample, frames, output ready);
endinterface

interface ltp_result_if;
    logic                                valid;
    logic                                ready;
    logic [ltp_pkg::POSITION_BITS-1:0]   position;
    logic                                playing;
    logic                                seek_pending;
    logic                                saturated;

    modport source (output valid, position, playing, seek_pending, saturated, input ready);
    modport sink   (input valid, position, playing, seek_pending, saturated, output ready);
endinterface

interface ltp_cfg_if;
    logic                                valid;
    logic                                ready;
    logic [ltp_pkg::CFG_IDX_BITS-1:0]    index;
    logic [ltp_pkg::POSITION_BITS-1:0]   data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

### hw/rtl/loop_transport_position_top.sv
// Top level of the loop transport position block: controller, datapath, channel wiring.
//
// Channels: items (command, seek_sample, frames) in, results (position, playing,
// seek_pending, saturated) out, cfg writes (index 0 loop enable, 1 loop range
// start, 2 loop range end) in. Every word moves on valid && ready at a rising clk edge.
// cfg.ready is always high; write cfg only while the block is idle.
// Each accepted item gives exactly one result word.
// Path from accept to result valid: begin/seek/play/stop and an advance that
// does not move go straight to the result load; an advance that moves passes
// the add, loop check and write-back steps first, and an advance that wraps
// inside the loop also runs the restoring divider for the loop modulo, which
// retires one bit per cycle (48 steps). One item is in flight at a time; the
// next item is taken as soon as the result is loaded into the output register,
// so the block cannot take a new item before it has finished the last one.
// Reset (rst_n low, asynchronous) clears position, seek target, play flags and
// loop registers to zero and empties the output register.
// A stalled receiver holds the result in the output register; a following item
// is still accepted and processed, and waits for the register to free up.
`default_nettype none

module loop_transport_position_top (
    input  wire logic   clk,
    input  wire logic   rst_n,
    ltp_item_if.sink    items,
    ltp_result_if.source results,
    ltp_cfg_if.sink     cfg
);

    ltp_pkg::ltp_cmd_t     cmd;
    ltp_pkg::ltp_status_t  status;

    assign cfg.ready = 1'b1;

    // Sequencer
    ltp_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (items.valid),
        .item_ready   (items.ready),
        .result_valid (results.valid),
        .result_ready (results.ready),
        .cmd          (cmd),
        .status       (status)
    );

    // State and arithmetic
    ltp_datapath u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .command      (items.command),
        .seek_sample  (items.seek_sample),
        .frames       (items.frames),
        .cfg_we       (cfg.valid && cfg.ready),
        .cfg_index    (cfg.index),
        .cfg_data     (cfg.data),
        .position     (results.position),
        .playing      (results.playing),
        .seek_pending (results.seek_pending),
        .saturated    (results.saturated)
    );

    // Only one sequencer step is active per cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.accept, cmd.do_add, cmd.do_check, cmd.do_div, cmd.do_fin,
                  cmd.load_out}))
    else $error("more than one sequencer step active");

    // The block is not ready again in the cycle after an accept
    assert property (@(posedge clk) disable iff (!rst_n)
        (items.valid && items.ready) |=> !items.ready)
    else $error("input taken again right after an accept");

    // Loading the result register always presents a word
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |=> results.valid)
    else $error("result loaded but not valid");

    // A clipped advance cannot coexist with a pending seek
    assert property (@(posedge clk) disable iff (!rst_n)
        (results.valid && results.saturated) |-> !results.seek_pending)
    else $error("saturated result reported with a seek pending");

endmodule

`default_nettype wire

### hw/rtl/ltp_datapath.sv
// Datapath: transport state, loop registers, saturating adder, serial divider, result register.
`default_nettype none

module ltp_datapath (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire ltp_pkg::ltp_cmd_t                   cmd,
    output      ltp_pkg::ltp_status_t                status,
    input  wire logic [ltp_pkg::CMD_BITS-1:0]        command,
    input  wire logic [ltp_pkg::POSITION_BITS-1:0]   seek_sample,
    input  wire logic [ltp_pkg::FRAME_BITS-1:0]      frames,
    input  wire logic                                cfg_we,
    input  wire logic [ltp_pkg::CFG_IDX_BITS-1:0]    cfg_index,
    input  wire logic [ltp_pkg::POSITION_BITS-1:0]   cfg_data,
    output      logic [ltp_pkg::POSITION_BITS-1:0]   position,
    output      logic                                playing,
    output      logic                                seek_pending,
    output      logic                                saturated
);

    localparam int PB = ltp_pkg::POSITION_BITS;
    localparam int FB = ltp_pkg::FRAME_BITS;

    // Architectural state
    logic [PB-1:0] sample_pos_reg;
    logic [PB-1:0] seek_target_reg;
    logic          seek_wait_reg;
    logic          play_req_reg;
    logic          play_lat_reg;
    logic          loop_en_reg;
    logic [PB-1:0] range_lo_reg;
    logic [PB-1:0] range_hi_reg;
    logic          lat_en_reg;
    logic [PB-1:0] lat_start_reg;
    logic [PB-1:0] lat_end_reg;

    // Working registers
    logic [FB-1:0] frames_reg;
    logic [PB-1:0] pos_reg;
    logic          sat_reg;
    logic          wrap_reg;
    logic [PB-1:0] dividend_reg;
    logic [PB-1:0] divisor_reg;
    logic [PB-1:0] rem_reg;

    // Result register
    logic [PB-1:0] out_pos_reg;
    logic          out_play_reg;
    logic          out_seek_reg;
    logic          out_sat_reg;

    logic [PB:0]   sum;
    logic [PB:0]   pos_minus_end;
    logic [PB:0]   span_len;
    logic          wrap_now;
    logic [PB:0]   rem_shift;
    logic [PB:0]   trial;
    logic [PB-1:0] sample_pos_next;

    // Advance decision on the offered word
    assign status.adv_go = (command == ltp_pkg::CMD_ADVANCE) && play_lat_reg &&
                           (frames != '0) && !seek_wait_reg;

    // Saturating add of the frame count
    assign sum = {1'b0, sample_pos_reg} + {{(PB + 1 - FB){1'b0}}, frames_reg};

    // Loop test: position at or past end, end strictly above start
    assign pos_minus_end = {1'b0, pos_reg} - {1'b0, lat_end_reg};
    assign span_len      = {1'b0, lat_end_reg} - {1'b0, lat_start_reg};
    assign wrap_now      = lat_en_reg && !span_len[PB] && (span_len[PB-1:0] != '0) &&
                           !pos_minus_end[PB];
    assign status.wrap   = wrap_now;

    // Restoring division step, one quotient bit per cycle
    assign rem_shift = {rem_reg, dividend_reg[PB-1]};
    assign trial     = rem_shift - {1'b0, divisor_reg};

    // Write-back value after an advance
    assign sample_pos_next = wrap_reg ? (lat_start_reg + rem_reg) : pos_reg;

    // Transport state and configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sample_pos_reg  <= '0;
            seek_target_reg <= '0;
            seek_wait_reg   <= 1'b0;
            play_req_reg    <= 1'b0;
            play_lat_reg    <= 1'b0;
            loop_en_reg     <= 1'b0;
            range_lo_reg    <= '0;
            range_hi_reg    <= '0;
            lat_en_reg      <= 1'b0;
            lat_start_reg   <= '0;
            lat_end_reg     <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    ltp_pkg::CFG_LOOP_ENABLE: loop_en_reg  <= cfg_data[0];
                    ltp_pkg::CFG_LOOP_START:  range_lo_reg <= cfg_data;
                    ltp_pkg::CFG_LOOP_END:    range_hi_reg <= cfg_data;
                    default: ;
                endcase
            end
            if (cmd.accept)
            begin
                case (command)
                    ltp_pkg::CMD_BEGIN:
                    begin
                        if (seek_wait_reg)
                        begin
                            sample_pos_reg <= seek_target_reg;
                            seek_wait_reg  <= 1'b0;
                        end
                        play_lat_reg  <= play_req_reg;
                        lat_en_reg    <= loop_en_reg;
                        lat_start_reg <= range_lo_reg;
                        lat_end_reg   <= range_hi_reg;
                    end
                    ltp_pkg::CMD_SEEK:
                    begin
                        seek_target_reg <= seek_sample;
                        seek_wait_reg   <= 1'b1;
                    end
                    ltp_pkg::CMD_PLAY: play_req_reg <= 1'b1;
                    ltp_pkg::CMD_STOP: play_req_reg <= 1'b0;
                    default: ;
                endcase
            end
            if (cmd.do_fin)
            begin
                sample_pos_reg <= sample_pos_next;
            end
        end
    end

    // Advance working registers and result payload
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            frames_reg <= frames;
            sat_reg    <= 1'b0;
        end
        if (cmd.do_add)
        begin
            if (sum[PB])
            begin
                pos_reg <= '1;
                sat_reg <= 1'b1;
            end
            else
            begin
                pos_reg <= sum[PB-1:0];
            end
        end
        if (cmd.do_check)
        begin
            wrap_reg     <= wrap_now;
            dividend_reg <= pos_minus_end[PB-1:0];
            divisor_reg  <= span_len[PB-1:0];
            rem_reg      <= '0;
        end
        if (cmd.do_div)
        begin
            dividend_reg <= {dividend_reg[PB-2:0], 1'b0};
            rem_reg      <= trial[PB] ? rem_shift[PB-1:0] : trial[PB-1:0];
        end
        if (cmd.load_out)
        begin
            out_pos_reg  <= seek_wait_reg ? seek_target_reg : sample_pos_reg;
            out_play_reg <= play_req_reg;
            out_seek_reg <= seek_wait_reg;
            out_sat_reg  <= sat_reg;
        end
    end

    assign position     = out_pos_reg;
    assign playing      = out_play_reg;
    assign seek_pending = out_seek_reg;
    assign saturated    = out_sat_reg;

endmodule

`default_nettype wire

### hw/rtl/ltp_ctrl.sv
// Controller: sequences accept, add, loop check, serial divide, write-back and result load.
`default_nettype none

module ltp_ctrl (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  item_valid,
    output      logic                  item_ready,
    output      logic                  result_valid,
    input  wire logic                  result_ready,
    output      ltp_pkg::ltp_cmd_t     cmd,
    input  wire ltp_pkg::ltp_status_t  status
);

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_ADD   = 6'b000010,
        S_CHECK = 6'b000100,
        S_DIV   = 6'b001000,
        S_FIN   = 6'b010000,
        S_EMIT  = 6'b100000
    } state_t;

    localparam logic [ltp_pkg::CNT_BITS-1:0] CNT_LAST =
        ltp_pkg::CNT_BITS'(ltp_pkg::POSITION_BITS - 1);

    state_t                        state_reg, state_next;
    logic [ltp_pkg::CNT_BITS-1:0]  cnt_reg, cnt_next;
    logic                          out_valid_reg, out_valid_next;
    logic                          out_free;

    assign item_ready   = (state_reg == S_IDLE);
    assign result_valid = out_valid_reg;
    assign out_free     = !out_valid_reg || result_ready;

    // Next state and command decode
    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg && !result_ready;
        cmd            = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (item_valid)
                begin
                    cmd.accept = 1'b1;
                    state_next = status.adv_go ? S_ADD : S_EMIT;
                end
            end
            S_ADD:
            begin
                cmd.do_add = 1'b1;
                state_next = S_CHECK;
            end
            S_CHECK:
            begin
                cmd.do_check = 1'b1;
                cnt_next     = '0;
                state_next   = status.wrap ? S_DIV : S_FIN;
            end
            S_DIV:
            begin
                cmd.do_div = 1'b1;
                cnt_next   = cnt_reg + 1'b1;
                if (cnt_reg == CNT_LAST)
                begin
                    state_next = S_FIN;
                end
            end
            S_FIN:
            begin
                cmd.do_fin = 1'b1;
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                if (out_free)
                begin
                    cmd.load_out   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

`default_nettype wire

### tb/ltp_checker.sv
// Checker for the loop transport position block: predicts every result word and compares it.
module ltp_checker
    import ltp_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    ltp_item_if   items,
    ltp_result_if results,
    ltp_cfg_if    cfg,
    output int    failures,
    output int    outstanding,
    output int    compared,
    output int    clips
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_REPORTS = 10;

    typedef struct packed {
        logic [POSITION_BITS-1:0] position;
        logic                     playing;
        logic                     seek_pending;
        logic                     saturated;
    } transport_word_t;

    // Transport state
    logic [POSITION_BITS-1:0] cur_pos;
    logic [POSITION_BITS-1:0] seek_to;
    logic                     seek_armed;
    logic                     play_req;
    logic                     play_quantum;

    // Loop registers as written, and the copy latched at quantum start
    logic                     loop_on;
    logic [POSITION_BITS-1:0] loop_lo;
    logic [POSITION_BITS-1:0] loop_hi;
    logic                     q_loop_on;
    logic [POSITION_BITS-1:0] q_loop_lo;
    logic [POSITION_BITS-1:0] q_loop_hi;

    transport_word_t expected_q[$];
    int              fail_count;
    int              compare_count;
    int              clip_count;

    // Apply one command to the transport and return the word it reports
    task automatic step_transport(
        input  logic [CMD_BITS-1:0]      cmd,
        input  logic [POSITION_BITS-1:0] target,
        input  logic [FRAME_BITS-1:0]    frames,
        output transport_word_t          word
    );
        logic [POSITION_BITS:0]   sum;
        logic [POSITION_BITS-1:0] pos;
        logic [POSITION_BITS-1:0] span;
        logic                     clipped;
        clipped = 1'b0;
        case (cmd)
            CMD_BEGIN:
            begin
                if (seek_armed)
                begin
                    cur_pos    = seek_to;
                    seek_armed = 1'b0;
                end
                play_quantum = play_req;
                q_loop_on    = loop_on;
                q_loop_lo    = loop_lo;
                q_loop_hi    = loop_hi;
            end
            CMD_ADVANCE:
            begin
                // no move while stopped, on zero frames, or with a seek since begin
                if (play_quantum && frames != '0 && !seek_armed)
                begin
                    sum = {1'b0, cur_pos} +
                          {{(POSITION_BITS + 1 - FRAME_BITS){1'b0}}, frames};
                    if (sum[POSITION_BITS])
                    begin
                        pos     = '1;
                        clipped = 1'b1;
                    end
                    else
                    begin
                        pos = sum[POSITION_BITS-1:0];
                    end
                    // wrap only with a nonempty range; an inverted range does not wrap
                    if (q_loop_on && q_loop_hi > q_loop_lo && pos >= q_loop_hi)
                    begin
                        span = q_loop_hi - q_loop_lo;
                        pos  = q_loop_lo + ((pos - q_loop_hi) % span);
                    end
                    cur_pos = pos;
                end
            end
            CMD_SEEK:
            begin
                seek_to    = target;
                seek_armed = 1'b1;
            end
            CMD_PLAY:
            begin
                play_req = 1'b1;
            end
            CMD_STOP:
            begin
                play_req = 1'b0;
            end
            default:
            begin
                // spare codes leave the state alone
            end
        endcase
        word.position     = seek_armed ? seek_to : cur_pos;
        word.playing      = play_req;
        word.seek_pending = seek_armed;
        word.saturated    = clipped;
    endtask

    // Watch the three channels: config writes, accepted commands, result words
    always @(posedge clk or negedge rst_n)
    begin : watch
        transport_word_t want;
        transport_word_t got;
        if (!rst_n)
        begin
            cur_pos       = '0;
            seek_to       = '0;
            seek_armed    = 1'b0;
            play_req      = 1'b0;
            play_quantum  = 1'b0;
            loop_on       = 1'b0;
            loop_lo       = '0;
            loop_hi       = '0;
            q_loop_on     = 1'b0;
            q_loop_lo     = '0;
            q_loop_hi     = '0;
            expected_q.delete();
            fail_count    = 0;
            compare_count = 0;
            clip_count    = 0;
            failures      <= 0;
            outstanding   <= 0;
            compared      <= 0;
            clips         <= 0;
        end
        else
        begin
            if (cfg.valid && cfg.ready)
            begin
                case (cfg.index)
                    CFG_LOOP_ENABLE: loop_on = cfg.data[0];
                    CFG_LOOP_START:  loop_lo = cfg.data;
                    CFG_LOOP_END:    loop_hi = cfg.data;
                    default:
                    begin
                    end
                endcase
            end

            if (items.valid && items.ready)
            begin
                step_transport(items.command, items.seek_sample, items.frames, want);
                expected_q.push_back(want);
            end

            if (results.valid && results.ready)
            begin
                got.position     = results.position;
                got.playing      = results.playing;
                got.seek_pending = results.seek_pending;
                got.saturated    = results.saturated;
                if (expected_q.size() == 0)
                begin
                    if (fail_count < MAX_REPORTS)
                        $display("%t: result word with none expected: %s%h %s%b %s%b %s%b",
                                 $realtime, "pos ", got.position, "play ", got.playing,
                                 "seek ", got.seek_pending, "sat ", got.saturated);
                    fail_count++;
                end
                else
                begin
                    want = expected_q.pop_front();
                    compare_count++;
                    if (want.saturated)
                        clip_count++;
                    if (got.position !== want.position || got.playing !== want.playing ||
                        got.seek_pending !== want.seek_pending ||
                        got.saturated !== want.saturated)
                    begin
                        if (fail_count < MAX_REPORTS)
                        begin
                            $display("%t: word %0d expected pos %h play %b seek %b sat %b,",
                                     $realtime, compare_count, want.position, want.playing,
                                     want.seek_pending, want.saturated);
                            $display("    got pos %h play %b seek %b sat %b",
                                     got.position, got.playing, got.seek_pending,
                                     got.saturated);
                        end
                        fail_count++;
                    end
                end
            end

            failures    <= fail_count;
            outstanding <= expected_q.size();
            compared    <= compare_count;
            clips       <= clip_count;
        end
    end

endmodule

### tb/testbench.sv
// Testbench top for the loop transport position block: clock, reset, stimulus and verdict.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import ltp_pkg::*;

    localparam logic [CMD_BITS-1:0]      CMD_SPARE_FIRST = 3'd5;
    localparam logic [CMD_BITS-1:0]      CMD_SPARE_LAST  = 3'd7;
    localparam logic [POSITION_BITS-1:0] POS_MAX         = '1;
    localparam logic [FRAME_BITS-1:0]    FRAMES_MAX      = '1;
    localparam int SETTLE_CYCLES = 64;       // longest wrap latency plus margin
    localparam int CYCLE_LIMIT   = 1000000;
    localparam int SEGMENT_WORDS = 78;
    localparam int LOOP_KINDS    = 7;

    logic clk = 1'b0;
    logic rst_n;

    int send_idle_pct;
    int recv_idle_pct;
    int sent_count;
    int setting_count;
    int cycle_count;
    int failures;
    int outstanding;
    int compared;
    int clips;

    // loop range last written, used to aim seeks
    logic [POSITION_BITS-1:0] cur_lo;
    logic [POSITION_BITS-1:0] cur_hi;

    ltp_item_if   item_ch();
    ltp_result_if result_ch();
    ltp_cfg_if    cfg_ch();

    loop_transport_position_top DUT (
        .clk     (clk),
        .rst_n   (rst_n),
        .items   (item_ch),
        .results (result_ch),
        .cfg     (cfg_ch)
    );

    ltp_checker transport_check (
        .clk         (clk),
        .rst_n       (rst_n),
        .items       (item_ch),
        .results     (result_ch),
        .cfg         (cfg_ch),
        .failures    (failures),
        .outstanding (outstanding),
        .compared    (compared),
        .clips       (clips)
    );

    // 2 ns clock
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Result receiver stalls at random
    always @(posedge clk)
    begin
        result_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    function automatic logic [POSITION_BITS-1:0] rand_pos();
        logic [63:0] raw;
        raw = {$urandom(), $urandom()};
        return raw[POSITION_BITS-1:0];
    endfunction

    // Seek targets mostly near the loop edges and full scale
    function automatic logic [POSITION_BITS-1:0] pick_target();
        case ($urandom_range(0, 5))
            0: return rand_pos();
            1: return cur_lo + POSITION_BITS'($urandom_range(0, 3000));
            2: return cur_hi - POSITION_BITS'($urandom_range(0, 70000));
            3: return POS_MAX - POSITION_BITS'($urandom_range(0, 70000));
            4: return POSITION_BITS'($urandom_range(0, 1000));
            default: return cur_hi + POSITION_BITS'($urandom_range(0, 1000));
        endcase
    endfunction

    // Offer one command word, with random idle cycles ahead of it
    task automatic send_word(
        input logic [CMD_BITS-1:0]      cmd,
        input logic [POSITION_BITS-1:0] target,
        input logic [FRAME_BITS-1:0]    frames
    );
        if ($urandom_range(99) < send_idle_pct)
        begin
            item_ch.valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < send_idle_pct);
        end
        item_ch.valid       <= 1'b1;
        item_ch.command     <= cmd;
        item_ch.seek_sample <= target;
        item_ch.frames      <= frames;
        do
            @(posedge clk);
        while (!item_ch.ready);
        sent_count++;
    endtask

    // Wait until every expected word is back and the block has settled
    task automatic drain();
        item_ch.valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic cfg_write(input logic [CFG_IDX_BITS-1:0] idx,
                             input logic [POSITION_BITS-1:0] value);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= value;
        do
            @(posedge clk);
        while (!cfg_ch.ready);
    endtask

    task automatic set_loop(input logic en,
                            input logic [POSITION_BITS-1:0] lo,
                            input logic [POSITION_BITS-1:0] hi);
        drain();
        cfg_write(CFG_LOOP_ENABLE, POSITION_BITS'(en));
        cfg_write(CFG_LOOP_START, lo);
        cfg_write(CFG_LOOP_END, hi);
        cfg_ch.valid <= 1'b0;
        cur_lo = lo;
        cur_hi = hi;
        setting_count++;
    endtask

    // Loop settings: off, short loop, inverted, empty, low range, top range, full range
    task automatic new_loop(input int kind);
        logic [POSITION_BITS-1:0] lo;
        lo = rand_pos();
        case (kind)
            0: set_loop(1'b0, lo, rand_pos());
            1: set_loop(1'b1, lo, lo + POSITION_BITS'($urandom_range(1, 2000)));
            2: set_loop(1'b1, lo, lo - POSITION_BITS'($urandom_range(1, 5000)));
            3: set_loop(1'b1, lo, lo);
            4: set_loop(1'b1, '0, POSITION_BITS'($urandom_range(1, 70000)));
            5: set_loop(1'b1, POS_MAX - POSITION_BITS'($urandom_range(1, 5000)),
                        POS_MAX - POSITION_BITS'($urandom_range(0, 1)));
            default: set_loop(1'b1, '0, POS_MAX);
        endcase
    endtask

    // Mostly begin/advance quanta while playing, with seeks, plays, stops and spare codes mixed in
    task automatic random_word();
        int                    pick;
        logic [FRAME_BITS-1:0] frames;
        case ($urandom_range(0, 19))
            0:       frames = '0;
            1:       frames = FRAMES_MAX;
            2, 3, 4, 5, 6, 7, 8, 9:
                     frames = FRAME_BITS'($urandom_range(1, 512));
            default: frames = FRAME_BITS'($urandom_range(0, 65535));
        endcase
        pick = $urandom_range(0, 99);
        if (pick < 34)
            send_word(CMD_BEGIN, rand_pos(), frames);
        else if (pick < 70)
            send_word(CMD_ADVANCE, rand_pos(), frames);
        else if (pick < 80)
            send_word(CMD_SEEK, pick_target(), frames);
        else if (pick < 88)
            send_word(CMD_PLAY, rand_pos(), frames);
        else if (pick < 92)
            send_word(CMD_STOP, rand_pos(), frames);
        else if (pick < 96)
            send_word(CMD_BITS'($urandom_range(CMD_SPARE_FIRST, CMD_SPARE_LAST)),
                      rand_pos(), frames);
        else
            send_word(CMD_SEEK, rand_pos(), frames);
    endtask

    // Stimulus and verdict
    initial
    begin
        rst_n               = 1'b0;
        item_ch.valid       = 1'b0;
        item_ch.command     = CMD_BEGIN;
        item_ch.seek_sample = '0;
        item_ch.frames      = '0;
        result_ch.ready     = 1'b0;
        cfg_ch.valid        = 1'b0;
        cfg_ch.index        = CFG_LOOP_ENABLE;
        cfg_ch.data         = '0;
        send_idle_pct       = 10;
        recv_idle_pct       = 88;
        sent_count          = 0;
        setting_count       = 0;
        cur_lo              = '0;
        cur_hi              = '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: stopped, spare codes, quantum gating, seek before begin, clipping
        send_word(CMD_ADVANCE, rand_pos(), FRAMES_MAX);
        send_word(CMD_SPARE_FIRST, POS_MAX, FRAMES_MAX);
        send_word(CMD_SPARE_LAST, '0, '0);
        send_word(CMD_PLAY, rand_pos(), '0);
        send_word(CMD_ADVANCE, rand_pos(), 16'd100);
        send_word(CMD_BEGIN, rand_pos(), FRAMES_MAX);
        send_word(CMD_ADVANCE, rand_pos(), '0);
        send_word(CMD_ADVANCE, rand_pos(), FRAMES_MAX);
        send_word(CMD_SEEK, POS_MAX - 48'd10, '0);
        send_word(CMD_ADVANCE, rand_pos(), 16'd5);
        send_word(CMD_BEGIN, rand_pos(), '0);
        send_word(CMD_ADVANCE, rand_pos(), FRAMES_MAX);
        send_word(CMD_ADVANCE, rand_pos(), 16'd1);
        send_word(CMD_STOP, rand_pos(), '0);
        send_word(CMD_BEGIN, rand_pos(), '0);
        send_word(CMD_ADVANCE, rand_pos(), 16'd50);
        send_word(CMD_SEEK, '0, '0);
        send_word(CMD_SEEK, 48'd1000, '0);
        send_word(CMD_PLAY, rand_pos(), '0);
        send_word(CMD_BEGIN, rand_pos(), '0);
        send_word(CMD_ADVANCE, rand_pos(), 16'd1);

        // Loop pinned at the top of the range: clip and wrap on the same advance
        set_loop(1'b1, POS_MAX - 48'd100, POS_MAX);
        send_word(CMD_SEEK, POS_MAX - 48'd50, '0);
        send_word(CMD_BEGIN, rand_pos(), '0);
        send_word(CMD_ADVANCE, rand_pos(), FRAMES_MAX);
        send_word(CMD_ADVANCE, rand_pos(), 16'd300);

        // Random: three pacing modes, every loop setting kind in each
        for (int phase = 0; phase < 3; phase++)
        begin
            case (phase)
                0:
                begin
                    send_idle_pct = 10;
                    recv_idle_pct = 88;
                end
                1:
                begin
                    send_idle_pct = 88;
                    recv_idle_pct = 10;
                end
                default:
                begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            for (int seg = 0; seg < LOOP_KINDS; seg++)
            begin
                new_loop((seg + 3 * phase) % LOOP_KINDS);
                repeat (SEGMENT_WORDS) random_word();
            end
        end

        drain();
        $display("Drove %0d command words through %0d loop settings and three pacing modes.",
                 sent_count, setting_count);
        $display("Compared %0d result words, %0d of them clipped at full scale.",
                 compared, clips);
        if (failures == 0 && outstanding == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // Cycle limit
    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Timed out after %0d cycles with %0d words outstanding.",
                 cycle_count, outstanding);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
